// File: rtl/core/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Shared constants and types for the PLL divider search.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int unsigned FREF_HZ      = 14318180;
  localparam int unsigned VCO_LIMIT_HZ = 230000000;
  localparam int unsigned DEF_MAX_N    = 32;
  localparam int unsigned DEF_MAX_M    = 128;
  localparam int unsigned MIN_N        = 2;

  localparam int unsigned TGT_W  = 30;
  localparam int unsigned REM_W  = 24;
  localparam int unsigned QT_W   = 7;
  localparam int unsigned QF_W   = 8;
  localparam int unsigned ADDR_W = 3;

  localparam logic REG_LOOP_DIV_LIMIT = 1'b0;

  localparam logic [REM_W-1:0] FREF = REM_W'(FREF_HZ);

  typedef struct packed {
    logic [QF_W-1:0]  qf;
    logic [REM_W-1:0] rf;
    logic [1:0]       ps_code;
    logic             ps_extra;
  } pds_job_t;

endpackage

// File: rtl/core/pds_if.sv
// ----------------------------------------------------------------------------
// pds_tgt_if / pds_res_if
// Valid/ready channels for targets and PLL settings.
// ----------------------------------------------------------------------------
interface pds_tgt_if;
  logic        valid;
  logic        ready;
  logic [29:0] target_hz;
  modport source (output valid, output target_hz, input ready);
  modport sink   (input valid, input target_hz, output ready);
endinterface

interface pds_res_if;
  logic       valid;
  logic       ready;
  logic [6:0] numerator_code;
  logic [4:0] denominator_code;
  logic       divide_by_2;
  logic [1:0] post_scale_code;
  logic       post_scale_extra;
  logic       found;
  modport source (output valid, output numerator_code, output denominator_code,
                  output divide_by_2, output post_scale_code, output post_scale_extra,
                  output found, input ready);
  modport sink   (input valid, input numerator_code, input denominator_code,
                  input divide_by_2, input post_scale_code, input post_scale_extra,
                  input found, output ready);
endinterface

// File: rtl/core/pds_front.sv
// ----------------------------------------------------------------------------
// pds_front
// Picks the post scaler and splits P*target into quotient and remainder of FREF.
// ----------------------------------------------------------------------------
module pds_front
  import pds_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [TGT_W-1:0] target_hz_i,
  input  logic             full_i,
  output logic             push_o,
  output pds_job_t         job_o
);

  logic              en;
  logic              v1_q, v2_q, v3_q;
  logic [TGT_W-1:0]  rem1_d, rem1_q;
  logic [REM_W-1:0]  rem2_d, rem2_q;
  logic [QT_W-1:0]   qt1_d, qt1_q, qt2_d, qt2_q;
  logic [3:0]        p_d, p1_q, p2_q;
  logic [1:0]        pc_d, pc1_q, pc2_q;
  logic              px_d, px1_q, px2_q;
  logic [27:0]       pr;
  logic [2:0]        q2;
  pds_job_t          job_d, job_q;

  assign en      = !(v3_q && full_i);
  assign ready_o = en;
  assign push_o  = v3_q && !full_i;
  assign job_o   = job_q;

  always_comb begin
    p_d = 4'd1; pc_d = 2'd0; px_d = 1'b0;
    if (target_hz_i < TGT_W'(VCO_LIMIT_HZ / 2)) begin p_d = 4'd2; pc_d = 2'd1; end
    if (target_hz_i < TGT_W'(VCO_LIMIT_HZ / 3)) begin p_d = 4'd3; pc_d = 2'd2; end
    if (target_hz_i < TGT_W'(VCO_LIMIT_HZ / 4)) begin p_d = 4'd4; pc_d = 2'd3; end
    if (target_hz_i < TGT_W'(VCO_LIMIT_HZ / 6)) begin p_d = 4'd6; pc_d = 2'd2; px_d = 1'b1; end
    if (target_hz_i < TGT_W'(VCO_LIMIT_HZ / 8)) begin p_d = 4'd8; pc_d = 2'd3; px_d = 1'b1; end
  end

  always_comb begin
    rem1_d = target_hz_i;
    qt1_d  = '0;
    for (int i = 6; i >= 3; i--) begin
      if ({7'd0, rem1_d} >= (37'(FREF) << i)) begin
        rem1_d    = TGT_W'({7'd0, rem1_d} - (37'(FREF) << i));
        qt1_d[i]  = 1'b1;
      end
    end
  end

  always_comb begin
    logic [TGT_W-1:0] r;
    r     = rem1_q;
    qt2_d = qt1_q;
    for (int i = 2; i >= 0; i--) begin
      if ({3'd0, r} >= (33'(FREF) << i)) begin
        r        = TGT_W'({3'd0, r} - (33'(FREF) << i));
        qt2_d[i] = 1'b1;
      end
    end
    rem2_d = r[REM_W-1:0];
  end

  always_comb begin
    logic [27:0] r;
    pr = 28'(rem2_q) * 28'(p2_q);
    r  = pr;
    q2 = '0;
    for (int i = 2; i >= 0; i--) begin
      if (r >= (28'(FREF) << i)) begin
        r     = r - (28'(FREF) << i);
        q2[i] = 1'b1;
      end
    end
    job_d.qf       = QF_W'(qt2_q) * QF_W'(p2_q) + QF_W'(q2);
    job_d.rf       = r[REM_W-1:0];
    job_d.ps_code  = pc2_q;
    job_d.ps_extra = px2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem1_q <= rem1_d; qt1_q <= qt1_d; p1_q <= p_d; pc1_q <= pc_d; px1_q <= px_d;
      rem2_q <= rem2_d; qt2_q <= qt2_d; p2_q <= p1_q; pc2_q <= pc1_q; px2_q <= px1_q;
      job_q  <= job_d;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("front pushes into full queue");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && full_i) |=> (v3_q && $stable(job_q))) else $error("stalled job lost");
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (job_q.rf < FREF)) else $error("remainder not reduced");

endmodule

// File: rtl/core/pds_fifo.sv
// ----------------------------------------------------------------------------
// pds_fifo
// Four-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module pds_fifo
  import pds_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pds_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output pds_job_t job_o
);

  pds_job_t   mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign full_o  = cnt_q[2];
  assign empty_o = (cnt_q == 3'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("queue count out of range");

endmodule

// File: rtl/core/pds_back.sv
// ----------------------------------------------------------------------------
// pds_back
// One pipeline stage per denominator N; keeps the best candidate so far.
// ----------------------------------------------------------------------------
module pds_back
  import pds_pkg::*;
#(
  parameter int unsigned MAX_N = DEF_MAX_N,
  parameter int unsigned MAX_M = DEF_MAX_M
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       lim2_i,
  input  logic       empty_i,
  input  pds_job_t   job_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [6:0] numerator_code_o,
  output logic [4:0] denominator_code_o,
  output logic       divide_by_2_o,
  output logic [1:0] post_scale_code_o,
  output logic       post_scale_extra_o,
  output logic       found_o
);

  localparam int unsigned NS = MAX_N - MIN_N + 1;
  localparam int unsigned NW = $clog2(MAX_N + 1);
  localparam int unsigned MW = $clog2(2 * MAX_M + 2);
  localparam int unsigned QW = QF_W + NW + 1;
  localparam int unsigned PW = REM_W + NW;

  logic en;
  logic             v_q    [NS];
  pds_job_t         job_q  [NS];
  logic [QW-1:0]    q_q    [NS];
  logic [REM_W-1:0] r_q    [NS];
  logic             have_q [NS];
  logic [REM_W-1:0] err_q  [NS];
  logic [MW-1:0]    m_q    [NS];
  logic [NW-1:0]    n_q    [NS];
  logic             v2_q   [NS];

  assign en    = !v_q[NS-1] || ready_i;
  assign pop_o = en && !empty_i;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [NW-1:0] N = NW'(k + MIN_N);
    pds_job_t         jb;
    logic             vin, hin, wrap, v2, gt_lim, up, mzero, better;
    logic [QW-1:0]    qin, qn, klim;
    logic [REM_W-1:0] rin, rn, ein, err;
    logic [REM_W:0]   rs;
    logic [MW-1:0]    min_, m;
    logic [NW-1:0]    nin;
    logic             vvin;
    logic [PW-1:0]    lhs, rhs;

    if (k == 0) begin : g_head
      always_comb begin
        vin = pop_o; jb = job_i; qin = QW'(job_i.qf); rin = job_i.rf;
        hin = 1'b0; ein = '0; min_ = '0; nin = '0; vvin = 1'b0;
      end
    end else begin : g_link
      always_comb begin
        vin = v_q[k-1]; jb = job_q[k-1]; qin = q_q[k-1]; rin = r_q[k-1];
        hin = have_q[k-1]; ein = err_q[k-1]; min_ = m_q[k-1]; nin = n_q[k-1];
        vvin = v2_q[k-1];
      end
    end

    always_comb begin
      rs     = {1'b0, rin} + {1'b0, jb.rf};
      wrap   = rs >= {1'b0, FREF};
      rn     = wrap ? REM_W'(rs - {1'b0, FREF}) : rs[REM_W-1:0];
      qn     = qin + QW'(jb.qf) + QW'(wrap);
      klim   = lim2_i ? QW'(2 * MAX_M) : QW'(MAX_M);
      gt_lim = (qn > klim) || (qn == klim && rn != '0);
      v2     = (qn > QW'(MAX_M)) || (qn == QW'(MAX_M) && rn != '0);
      up     = v2 ? qn[0] : ({1'b0, rn, 1'b0} >= {2'b0, FREF});
      m      = v2 ? MW'((qn + QW'(1)) >> 1) : MW'(qn + QW'(up));
      mzero  = !v2 && qn == '0 && !up;
      err    = up ? FREF - rn : rn;
      lhs    = PW'(err) * PW'(nin);
      rhs    = PW'(ein) * PW'(N);
      better = !gt_lim && !mzero && (!hin || lhs < rhs);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        job_q[k]  <= jb;
        q_q[k]    <= qn;
        r_q[k]    <= rn;
        have_q[k] <= hin || better;
        err_q[k]  <= better ? err : ein;
        m_q[k]    <= better ? m : min_;
        n_q[k]    <= better ? N : nin;
        v2_q[k]   <= better ? v2 : vvin;
      end
    end
  end

  logic [MW-1:0] mm1;
  logic [NW-1:0] nm1;
  assign mm1 = m_q[NS-1] - MW'(1);
  assign nm1 = n_q[NS-1] - NW'(1);

  assign valid_o            = v_q[NS-1];
  assign found_o            = have_q[NS-1];
  assign numerator_code_o   = found_o ? mm1[6:0] : '0;
  assign denominator_code_o = found_o ? nm1[4:0] : '0;
  assign divide_by_2_o      = found_o && v2_q[NS-1];
  assign post_scale_code_o  = found_o ? job_q[NS-1].ps_code : '0;
  assign post_scale_extra_o = found_o && job_q[NS-1].ps_extra;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(found_o) && $stable(numerator_code_o)))
    else $error("result changed under stall");
  a_div2_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && divide_by_2_o) |-> lim2_i) else $error("divide-by-2 without limit 2");
  a_m_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && found_o) |-> (m_q[NS-1] != '0 && m_q[NS-1] <= MW'(MAX_M)))
    else $error("numerator out of range");

endmodule

// File: rtl/core/pll_divider_search.sv
// ----------------------------------------------------------------------------
// pll_divider_search
// Target pixel clock in, PLL M/N/P settings out.
//
//   channel  dir  beat / notes
//   tgt_i    in   target_hz
//   res_o    out  numerator, denominator, divide_by_2, post scale, found
//   apb      in   reg 0 loop_div_limit at byte address 0
//
// One target per cycle sustained while the queue has room. A target passes through
// the front pipeline, the queue, then the back stages, one per denominator.
// Front and back stall independently through a four-entry queue; the back stalls
// only when its last stage holds an untaken result. Reset sets loop_div_limit to 1.
// ----------------------------------------------------------------------------
module pll_divider_search
  import pds_pkg::*;
#(
  parameter int unsigned MAX_N = DEF_MAX_N,
  parameter int unsigned MAX_M = DEF_MAX_M
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pds_tgt_if.sink           tgt_i,
  pds_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [1:0]    lim_q;
  logic          full, empty, pop, push;
  pds_job_t      job_in, job_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LOOP_DIV_LIMIT) ? {30'd0, lim_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= 2'd1;
    end else if (psel && penable && pwrite && paddr[2] == REG_LOOP_DIV_LIMIT) begin
      lim_q <= pwdata[1:0];
    end
  end

  pds_front u_front (
    .clk_i, .rst_ni,
    .valid_i(tgt_i.valid), .ready_o(tgt_i.ready), .target_hz_i(tgt_i.target_hz),
    .full_i(full), .push_o(push), .job_o(job_in)
  );

  pds_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .job_i(job_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .job_o(job_out)
  );

  pds_back #(.MAX_N(MAX_N), .MAX_M(MAX_M)) u_back (
    .clk_i, .rst_ni,
    .lim2_i(lim_q[1]), .empty_i(empty), .job_i(job_out), .pop_o(pop),
    .valid_o(res_o.valid), .ready_i(res_o.ready),
    .numerator_code_o(res_o.numerator_code),
    .denominator_code_o(res_o.denominator_code),
    .divide_by_2_o(res_o.divide_by_2),
    .post_scale_code_o(res_o.post_scale_code),
    .post_scale_extra_o(res_o.post_scale_extra),
    .found_o(res_o.found)
  );

endmodule

// File: verif/tb_pll_divider_search.sv
// ----------------------------------------------------------------------------
// tb_pll_divider_search
// Testbench for the PLL divider search. Targets are sent through the target
// channel, and an internal predictor works out the expected PLL settings by
// exact integer search over every denominator. Each result beat is checked
// field by field against the oldest expected setting. Both channels idle at
// random, and the loop divider limit is changed between phases.
// ----------------------------------------------------------------------------
module tb_pll_divider_search;
  import pds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT_CYC = 40;
  localparam int WD_LIMIT = 4000;

  typedef struct packed {
    logic [6:0] m_code;
    logic [4:0] n_code;
    logic       div2;
    logic [1:0] ps_code;
    logic       ps_extra;
    logic       found;
  } pll_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pds_tgt_if tgt ();
  pds_res_if res ();

  pll_divider_search dut (
    .clk_i(clk), .rst_ni(rst_n), .tgt_i(tgt.sink), .res_o(res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    tgt.valid = 1'b0;
    tgt.target_hz = '0;
    res.ready = 1'b0;
  end

  pll_set_t setting_q[$];
  bit [1:0] loop_limit_reg = 2'd1;
  int errors = 0;
  int idle_cycles = 0;
  bit sending = 1'b1;

  function automatic pll_set_t search_pll(bit [29:0] t);
    pll_set_t s;
    longint unsigned lim, p, num, m, v, fv, err, den;
    longint unsigned b_err, b_den, b_m, b_n, b_v;
    bit have;
    s = '0;
    have = 1'b0;
    b_err = 0; b_den = 1; b_m = 0; b_n = 0; b_v = 1;
    if (t == 0) return s;
    lim = (loop_limit_reg >= 2) ? 2 : 1;
    p = 1;
    if (t < VCO_LIMIT_HZ / 2) p = 2;
    if (t < VCO_LIMIT_HZ / 3) p = 3;
    if (t < VCO_LIMIT_HZ / 4) p = 4;
    if (t < VCO_LIMIT_HZ / 6) p = 6;
    if (t < VCO_LIMIT_HZ / 8) p = 8;
    for (longint unsigned n = MIN_N; n <= DEF_MAX_N; n++) begin
      num = p * t * n;
      if (num > longint'(DEF_MAX_M) * lim * FREF_HZ) continue;
      if (num > longint'(DEF_MAX_M) * FREF_HZ) begin
        m = (num + FREF_HZ) / (2 * FREF_HZ);
        v = 2;
      end else begin
        m = (2 * num + FREF_HZ) / (2 * FREF_HZ);
        v = 1;
      end
      if (m == 0) continue;
      fv = FREF_HZ * m * v;
      err = (num > fv) ? num - fv : fv - num;
      den = n * p;
      if (!have || err * b_den < b_err * den) begin
        have = 1'b1;
        b_err = err; b_den = den; b_m = m; b_n = n; b_v = v;
      end
    end
    if (!have) return s;
    case (p)
      1: begin s.ps_code = 0; s.ps_extra = 0; end
      2: begin s.ps_code = 1; s.ps_extra = 0; end
      3: begin s.ps_code = 2; s.ps_extra = 0; end
      4: begin s.ps_code = 3; s.ps_extra = 0; end
      6: begin s.ps_code = 2; s.ps_extra = 1; end
      default: begin s.ps_code = 3; s.ps_extra = 1; end
    endcase
    s.m_code = 7'(b_m - 1);
    s.n_code = 5'(b_n - 1);
    s.div2 = (b_v == 2);
    s.found = 1'b1;
    return s;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic send_target(bit [29:0] t);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      tgt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tgt.valid <= 1'b1;
    tgt.target_hz <= t;
    @(posedge clk);
    while (!tgt.ready) @(posedge clk);
    setting_q.push_back(search_pll(t));
  endtask

  task automatic drain();
    tgt.valid <= 1'b0;
    while (setting_q.size() != 0) @(posedge clk);
    repeat (LAT_CYC) @(posedge clk);
  endtask

  task automatic write_limit(bit [1:0] val);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(REG_LOOP_DIV_LIMIT);
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    loop_limit_reg = val;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // sink side: random stall per beat
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pll_set_t e;
    if (res.valid && res.ready) begin
      if (setting_q.size() == 0) begin
        $display("unexpected result beat");
        errors++;
      end else begin
        e = setting_q.pop_front();
        if (res.numerator_code != e.m_code) report("numerator", res.numerator_code, e.m_code);
        if (res.denominator_code != e.n_code)
          report("denominator", res.denominator_code, e.n_code);
        if (res.divide_by_2 != e.div2) report("divide_by_2", res.divide_by_2, e.div2);
        if (res.post_scale_code != e.ps_code)
          report("post_scale", res.post_scale_code, e.ps_code);
        if (res.post_scale_extra != e.ps_extra)
          report("post_scale_extra", res.post_scale_extra, e.ps_extra);
        if (res.found != e.found) report("found", res.found, e.found);
      end
    end
  end

  always @(posedge clk) begin
    if ((tgt.valid && tgt.ready) || (res.valid && res.ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb_pll_divider_search NOT OK");
      $finish;
    end
  end

  function automatic bit [29:0] rand_target();
    case ($urandom_range(0, 5))
      0: return 30'($urandom);
      1: return 30'($urandom_range(1, 30000000));
      2: return 30'($urandom_range(28000000, 240000000));
      3: return 30'($urandom_range(1, 200000));
      4: return 30'($urandom_range(VCO_LIMIT_HZ / 8 - 4, VCO_LIMIT_HZ / 8 + 4));
      default: return 30'($urandom_range(200000000, 1073741823));
    endcase
  endfunction

  task automatic test_directed();
    bit [29:0] dir[$];
    dir = '{30'd0, 30'd1, 30'd2, 30'h3FFFFFFF, 30'd55944, 30'd55000, 30'd100000,
            30'(VCO_LIMIT_HZ / 2), 30'(VCO_LIMIT_HZ / 2 - 1), 30'(VCO_LIMIT_HZ / 3 - 1),
            30'(VCO_LIMIT_HZ / 4 - 1), 30'(VCO_LIMIT_HZ / 6 - 1), 30'(VCO_LIMIT_HZ / 8 - 1),
            30'(VCO_LIMIT_HZ / 8), 30'd25175000, 30'd65000000, 30'd230000000,
            30'd300000000, 30'h15555555, 30'h2AAAAAAA};
    foreach (dir[i]) send_target(dir[i]);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_target(rand_target());
      if (i == count / 2) drain();
    end
  endtask

  initial begin : main
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250);
    write_limit(2'd2);
    test_directed();
    test_random(300);
    write_limit(2'd0);
    test_random(150);
    write_limit(2'd3);
    test_directed();
    test_random(300);
    write_limit(2'd1);
    test_random(150);
    drain();
    if (errors == 0) $display("tb_pll_divider_search OK");
    else $display("tb_pll_divider_search NOT OK");
    $finish;
  end
endmodule
